// ----- rtl/modexp_pkg.sv -----
// shared types, widths and control program for the modular exponentiation block
// used by modexp_reduce and modular_exponentiation; no dependencies
`default_nettype none

package modexp_pkg;

    localparam int MOD_W      = 31;
    localparam int EXP_W      = 32;
    localparam int BASE_W     = 31;
    localparam int DIV_W      = 2 * MOD_W + 2;
    localparam int RED_DIGIT  = 4;
    localparam int RED_STEPS  = DIV_W / RED_DIGIT;
    localparam int RED_CNT_W  = $clog2(RED_STEPS);
    localparam int EXP_CNT_W  = $clog2(EXP_W);
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 32;
    localparam int PC_W       = 5;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED_B,
        OP_SET_B,
        OP_MUL_SQ,
        OP_MUL_B,
        OP_RED_P,
        OP_SET_R,
        OP_NEXT,
        OP_OUT_R,
        OP_OUT_BAD,
        OP_OUT_ONE
    } op_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NEVER,
        C_NO_IN,
        C_M_ZERO,
        C_E_ZERO,
        C_RED_BUSY,
        C_EBIT_CLR,
        C_CNT_NZ,
        C_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_word_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [MOD_W-1:0]  modulus;
    } red_req_t;

    typedef struct packed {
        logic              busy;
        logic [MOD_W-1:0]  rem;
    } red_stat_t;

    localparam logic [PC_W-1:0] PC_WAIT_IN = PC_W'(0);
    localparam logic [PC_W-1:0] PC_WAIT_B  = PC_W'(4);
    localparam logic [PC_W-1:0] PC_SQ      = PC_W'(6);
    localparam logic [PC_W-1:0] PC_WAIT_S  = PC_W'(8);
    localparam logic [PC_W-1:0] PC_WAIT_M  = PC_W'(12);
    localparam logic [PC_W-1:0] PC_NEXT    = PC_W'(14);
    localparam logic [PC_W-1:0] PC_OUT_W   = PC_W'(15);
    localparam logic [PC_W-1:0] PC_BAD_W   = PC_W'(17);
    localparam logic [PC_W-1:0] PC_ONE_W   = PC_W'(19);

    // control program: jump to target when cond holds, else fall through
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{op: OP_NONE, cond: C_ALWAYS, target: PC_WAIT_IN};
        case (pc)
            5'd0:    w = '{op: OP_LOAD,    cond: C_NO_IN,    target: PC_WAIT_IN};
            5'd1:    w = '{op: OP_NONE,    cond: C_M_ZERO,   target: PC_BAD_W};
            5'd2:    w = '{op: OP_NONE,    cond: C_E_ZERO,   target: PC_ONE_W};
            5'd3:    w = '{op: OP_RED_B,   cond: C_NEVER,    target: PC_WAIT_IN};
            5'd4:    w = '{op: OP_NONE,    cond: C_RED_BUSY, target: PC_WAIT_B};
            5'd5:    w = '{op: OP_SET_B,   cond: C_NEVER,    target: PC_WAIT_IN};
            5'd6:    w = '{op: OP_MUL_SQ,  cond: C_NEVER,    target: PC_WAIT_IN};
            5'd7:    w = '{op: OP_RED_P,   cond: C_NEVER,    target: PC_WAIT_IN};
            5'd8:    w = '{op: OP_NONE,    cond: C_RED_BUSY, target: PC_WAIT_S};
            5'd9:    w = '{op: OP_SET_R,   cond: C_EBIT_CLR, target: PC_NEXT};
            5'd10:   w = '{op: OP_MUL_B,   cond: C_NEVER,    target: PC_WAIT_IN};
            5'd11:   w = '{op: OP_RED_P,   cond: C_NEVER,    target: PC_WAIT_IN};
            5'd12:   w = '{op: OP_NONE,    cond: C_RED_BUSY, target: PC_WAIT_M};
            5'd13:   w = '{op: OP_SET_R,   cond: C_NEVER,    target: PC_WAIT_IN};
            5'd14:   w = '{op: OP_NEXT,    cond: C_CNT_NZ,   target: PC_SQ};
            5'd15:   w = '{op: OP_NONE,    cond: C_OUT_FULL, target: PC_OUT_W};
            5'd16:   w = '{op: OP_OUT_R,   cond: C_ALWAYS,   target: PC_WAIT_IN};
            5'd17:   w = '{op: OP_NONE,    cond: C_OUT_FULL, target: PC_BAD_W};
            5'd18:   w = '{op: OP_OUT_BAD, cond: C_ALWAYS,   target: PC_WAIT_IN};
            5'd19:   w = '{op: OP_NONE,    cond: C_OUT_FULL, target: PC_ONE_W};
            5'd20:   w = '{op: OP_OUT_ONE, cond: C_ALWAYS,   target: PC_WAIT_IN};
            default: w = '{op: OP_NONE,    cond: C_ALWAYS,   target: PC_WAIT_IN};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/modexp_reduce.sv -----
// shift-subtract reduction unit: remainder of a 64-bit dividend by the modulus,
// four dividend bits per cycle; depends on modexp_pkg
`default_nettype none

module modexp_reduce (
    input  wire                   clk,
    input  wire                   rst_n,
    input  modexp_pkg::red_req_t  req,
    output modexp_pkg::red_stat_t stat
);
    import modexp_pkg::*;

    logic                 busy_reg, busy_next;
    logic [RED_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     div_reg, div_next;
    logic [MOD_W-1:0]     rem_reg, rem_next;
    logic [MOD_W-1:0]     mod_reg, mod_next;

    always_comb
    begin
        logic [MOD_W:0]   t;
        logic [MOD_W-1:0] acc;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        mod_next  = mod_reg;
        acc       = rem_reg;
        for (int i = 0; i < RED_DIGIT; i++)
        begin
            t = {acc, div_reg[DIV_W-1-i]};
            if (t >= {1'b0, mod_reg})
            begin
                t = t - {1'b0, mod_reg};
            end
            acc = t[MOD_W-1:0];
        end
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = RED_CNT_W'(RED_STEPS - 1);
            div_next  = req.dividend;
            rem_next  = '0;
            mod_next  = req.modulus;
        end
        else if (busy_reg)
        begin
            rem_next = acc;
            div_next = div_reg << RED_DIGIT;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        mod_reg <= mod_next;
    end

    assign stat.busy = busy_reg;
    assign stat.rem  = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/modular_exponentiation.sv -----
// top level: microcoded square-and-multiply sequencer with one product register
// and one shared reduction unit; depends on modexp_pkg and modexp_reduce
//
// usage
//   input stream s_*: one transfer carries base_value, exponent and modulus.
//   output stream m_*: one transfer per input, power_result in m_tdata and
//   bad_modulus in m_tuser.
//   s_tready is high only while the sequencer sits at its entry step, so one
//   item is worked on at a time.
//   a zero modulus or a zero exponent is answered without the square-and-
//   multiply loop; otherwise every one of the 32 exponent bits costs a
//   squaring and each set exponent bit a multiply as well. the base and
//   each product are reduced by the shared reduction unit, 4 bits a cycle.
//   a finished result sits in an output register; the next item is accepted
//   while it waits. if the receiver stalls, the following result waits at the
//   end of its program until the output register frees.
//   reset clears the sequencer, the reduction unit and the output valid flag.
`default_nettype none

module modular_exponentiation (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // base_value[30:0], exponent[62:31], modulus[93:63], zero fill
    input  wire  [modexp_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // power_result[30:0], zero fill
    output logic [modexp_pkg::OUT_DATA_W-1:0]   m_tdata,
    // bad_modulus[0]
    output logic                                m_tuser
);
    import modexp_pkg::*;

    logic [PC_W-1:0]      pc_reg, pc_next;
    logic [BASE_W-1:0]    b_reg, b_next;
    logic [EXP_W-1:0]     e_reg, e_next;
    logic [MOD_W-1:0]     m_reg, m_next;
    logic [MOD_W-1:0]     r_reg, r_next;
    logic [2*MOD_W-1:0]   prod_reg, prod_next;
    logic [EXP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MOD_W-1:0]     out_data_reg, out_data_next;
    logic                 out_bad_reg, out_bad_next;

    ctrl_word_t cw;
    red_req_t   red_req;
    red_stat_t  red_stat;
    logic       in_xfer;
    logic       out_full;
    logic       cond_true;

    modexp_reduce u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (red_req),
        .stat  (red_stat)
    );

    assign cw       = ucode_rom(pc_reg);
    assign s_tready = (pc_reg == PC_WAIT_IN);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_full = out_valid_reg && !m_tready;

    // sequencer
    always_comb
    begin
        case (cw.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_NEVER:    cond_true = 1'b0;
            C_NO_IN:    cond_true = !s_tvalid;
            C_M_ZERO:   cond_true = (m_reg == '0);
            C_E_ZERO:   cond_true = (e_reg == '0);
            C_RED_BUSY: cond_true = red_stat.busy;
            C_EBIT_CLR: cond_true = !e_reg[EXP_W-1];
            C_CNT_NZ:   cond_true = (cnt_reg != '0);
            C_OUT_FULL: cond_true = out_full;
            default:    cond_true = 1'b0;
        endcase
        pc_next = cond_true ? cw.target : pc_reg + 1'b1;
    end

    // datapath
    always_comb
    begin
        b_next         = b_reg;
        e_next         = e_reg;
        m_next         = m_reg;
        r_next         = r_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        out_data_next  = out_data_reg;
        out_bad_next   = out_bad_reg;
        out_valid_next = out_valid_reg && !m_tready;
        red_req.start    = 1'b0;
        red_req.dividend = {2'b00, prod_reg};
        red_req.modulus  = m_reg;
        case (cw.op)
            OP_LOAD:
            begin
                if (in_xfer)
                begin
                    b_next = s_tdata[BASE_W-1:0];
                    e_next = s_tdata[BASE_W +: EXP_W];
                    m_next = s_tdata[BASE_W+EXP_W +: MOD_W];
                end
            end
            OP_RED_B:
            begin
                red_req.start    = 1'b1;
                red_req.dividend = {{(DIV_W-BASE_W){1'b0}}, b_reg};
            end
            OP_SET_B:
            begin
                b_next   = red_stat.rem;
                r_next   = (m_reg == MOD_W'(1)) ? '0 : MOD_W'(1);
                cnt_next = EXP_CNT_W'(EXP_W - 1);
            end
            OP_MUL_SQ:
            begin
                prod_next = r_reg * r_reg;
            end
            OP_MUL_B:
            begin
                prod_next = r_reg * b_reg;
            end
            OP_RED_P:
            begin
                red_req.start = 1'b1;
            end
            OP_SET_R:
            begin
                r_next = red_stat.rem;
            end
            OP_NEXT:
            begin
                e_next   = e_reg << 1;
                cnt_next = cnt_reg - 1'b1;
            end
            OP_OUT_R:
            begin
                out_valid_next = 1'b1;
                out_data_next  = r_reg;
                out_bad_next   = 1'b0;
            end
            OP_OUT_BAD:
            begin
                out_valid_next = 1'b1;
                out_data_next  = '0;
                out_bad_next   = 1'b1;
            end
            OP_OUT_ONE:
            begin
                out_valid_next = 1'b1;
                out_data_next  = MOD_W'(1);
                out_bad_next   = 1'b0;
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_WAIT_IN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg        <= b_next;
        e_reg        <= e_next;
        m_reg        <= m_next;
        r_reg        <= r_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
        out_bad_reg  <= out_bad_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-MOD_W){1'b0}}, out_data_reg};
    assign m_tuser  = out_bad_reg;

endmodule

`default_nettype wire

// ----- rtl/modexp_checker.sv -----
// port-level checks for modular_exponentiation, attached by bind
// depends on modexp_pkg for the port widths
`default_nettype none

module modexp_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               s_tvalid,
    input wire                               s_tready,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [modexp_pkg::OUT_DATA_W-1:0]  m_tdata,
    input wire                               m_tuser
);
    import modexp_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // a zero modulus gives a zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("bad modulus with nonzero result");

    // the result fits the modulus width
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:MOD_W] == '0)
        else $error("result wider than modulus");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
